// File: hw/rtl/tmd_pkg.sv
// Shared types and constants for the matrix decompose pipeline.
// No dependencies; every file of the block imports this package.
package tmd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int NCOMP     = 9;
    localparam int NQ        = 4;
    localparam int NPOS      = 3;

    // square root unit: 64-bit radicand, one result bit per stage
    localparam int SQRT_IN_W = 64;
    localparam int ROOT_W    = SQRT_IN_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int SQRT_LAT  = ROOT_W;

    // fraction divider: num * 2^30 / den with num <= den
    localparam int QUOT_W    = 31;
    localparam int DIV_LAT   = QUOT_W;

    // branch vector and normalization
    localparam int VEC_W     = 35;
    localparam int MAG_W     = 33;
    localparam int UNIT_W    = 31;
    localparam int SHL_W     = 5;
    localparam int SHR_W     = 2;
    localparam int QUAT_LAT  = 6;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic        [WORD_W-1:0] uword_t;
    typedef word_t [NCOMP-1:0]        mat_t;

    typedef struct packed {
        logic [NQ-1:0][UNIT_W-1:0] mag;
        logic [NQ-1:0]             neg;
    } tmd_qvec_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] c0x;
        logic signed [WORD_W-1:0] c0y;
        logic signed [WORD_W-1:0] c0z;
        logic signed [WORD_W-1:0] c1x;
        logic signed [WORD_W-1:0] c1y;
        logic signed [WORD_W-1:0] c1z;
        logic signed [WORD_W-1:0] c2x;
        logic signed [WORD_W-1:0] c2y;
        logic signed [WORD_W-1:0] c2z;
        logic signed [WORD_W-1:0] tx_in;
        logic signed [WORD_W-1:0] ty_in;
        logic signed [WORD_W-1:0] tz_in;
    } tmd_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
        logic signed [WORD_W-1:0] quat_w;
        logic signed [WORD_W-1:0] quat_x;
        logic signed [WORD_W-1:0] quat_y;
        logic signed [WORD_W-1:0] quat_z;
        logic        [WORD_W-1:0] scale_x;
        logic        [WORD_W-1:0] scale_y;
        logic        [WORD_W-1:0] scale_z;
    } tmd_out_t;

endpackage

// File: hw/rtl/trs_matrix_decompose.sv
// Top level of the transform decompose block: position, rotation and scale.
// Depends on tmd_pkg, tmd_isqrt, tmd_div and tmd_quat.
//
// Splits a 3x3 basis plus translation into position, unit quaternion (Q2.30)
// and per-column scale (Q16.16). One matrix is taken per clock while the
// output is not stalled. The pipeline depth comes from two 32-stage
// square-root pipelines (column lengths, then the quaternion norm) and two
// 31-stage fraction dividers (column normalization, then quaternion
// scaling), plus the branch and shift stages.
// A stalled output freezes the whole pipe; the input register still takes
// one more transfer while the output waits. No state survives between items.
module trs_matrix_decompose (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tmd_pkg::tmd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tmd_pkg::tmd_out_t m_data
);
    import tmd_pkg::*;

    // stage numbers, counted from the first register after the input register
    localparam int ST_A    = 0;
    localparam int ST_C    = ST_A + 2;
    localparam int ST_SQ1  = ST_C + SQRT_LAT;
    localparam int ST_E    = ST_SQ1 + 1;
    localparam int ST_DIV1 = ST_E + DIV_LAT;
    localparam int ST_F    = ST_DIV1 + 1;
    localparam int ST_QT   = ST_F + QUAT_LAT;
    localparam int ST_G    = ST_QT + 1;
    localparam int ST_H    = ST_G + 1;
    localparam int ST_SQ2  = ST_H + SQRT_LAT;
    localparam int ST_I    = ST_SQ2 + 1;
    localparam int ST_DIV2 = ST_I + DIV_LAT;
    localparam int ST_J    = ST_DIV2 + 1;

    // side-band delay lengths
    localparam int DLY_MAG = ST_E - ST_A;
    localparam int DLY_NEG = ST_DIV1 - ST_A;
    localparam int DLY_POS = ST_DIV2 - ST_A + 1;
    localparam int DLY_LEN = ST_DIV2 - ST_E;
    localparam int DLY_VEC = ST_I - ST_QT;
    localparam int DLY_SGN = ST_DIV2 - ST_QT;

    // ---------------------------------------------------------------
    // flow control: advance everything when the output is free
    // ---------------------------------------------------------------
    logic        en;
    logic        in_vld_reg;
    tmd_in_t     in_reg;
    logic [ST_J:0] vld_reg;

    assign en      = !vld_reg[ST_J] || m_ready;
    assign s_ready = en || !in_vld_reg;
    assign m_valid = vld_reg[ST_J];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            vld_reg    <= '0;
        end else begin
            // hold the input register until the pipe advances
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (en) begin
                in_vld_reg <= 1'b0;
            end
            if (en) begin
                vld_reg <= {vld_reg[ST_J-1:0], in_vld_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    word_t cin [NCOMP];

    always_comb begin
        cin[0] = in_reg.c0x;
        cin[1] = in_reg.c0y;
        cin[2] = in_reg.c0z;
        cin[3] = in_reg.c1x;
        cin[4] = in_reg.c1y;
        cin[5] = in_reg.c1z;
        cin[6] = in_reg.c2x;
        cin[7] = in_reg.c2y;
        cin[8] = in_reg.c2z;
    end

    // ---------------------------------------------------------------
    // column lengths: |c|, squares, sum, square root
    // ---------------------------------------------------------------
    uword_t [NCOMP-1:0]   mag_a_reg;
    logic   [NCOMP-1:0]   neg_a_reg;
    logic [SQRT_IN_W-1:0] sq_b_reg  [NCOMP];
    logic [SQRT_IN_W-1:0] sum_c_reg [NPOS];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NCOMP; k++) begin
                neg_a_reg[k] <= cin[k][WORD_W-1];
                mag_a_reg[k] <= cin[k][WORD_W-1] ? uword_t'(-cin[k]) : uword_t'(cin[k]);
                sq_b_reg[k]  <= mag_a_reg[k] * mag_a_reg[k];
            end
            for (int j = 0; j < NPOS; j++) begin
                sum_c_reg[j] <= sq_b_reg[3*j] + sq_b_reg[3*j+1] + sq_b_reg[3*j+2];
            end
        end
    end

    logic [ROOT_W-1:0] root1 [NPOS];
    uword_t            len_e_reg [NPOS];

    genvar j;
    generate
        for (j = 0; j < NPOS; j++) begin : g_len
            tmd_isqrt u_len_sqrt (
                .aclk     (aclk),
                .en       (en),
                .radicand (sum_c_reg[j]),
                .root     (root1[j])
            );
        end
    endgenerate

    // the root of three 32-bit squares fits 32 bits, so saturation never bites;
    // an all-zero column gets scale one
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NPOS; i++) begin
                len_e_reg[i] <= (root1[i] == '0) ? (uword_t'(1) << FRAC_BITS) : root1[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // side-band delay lines, aligned to the stage that consumes them
    // ---------------------------------------------------------------
    uword_t [NCOMP-1:0] mag_dly_reg [DLY_MAG];
    logic   [NCOMP-1:0] neg_dly_reg [DLY_NEG];
    word_t  [NPOS-1:0]  pos_dly_reg [DLY_POS];
    uword_t [NPOS-1:0]  len_dly_reg [DLY_LEN];
    tmd_qvec_t          vec_dly_reg [DLY_SGN];
    tmd_qvec_t          vec_q;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_dly_reg[0] <= mag_a_reg;
            for (int i = 1; i < DLY_MAG; i++) begin
                mag_dly_reg[i] <= mag_dly_reg[i-1];
            end
            neg_dly_reg[0] <= neg_a_reg;
            for (int i = 1; i < DLY_NEG; i++) begin
                neg_dly_reg[i] <= neg_dly_reg[i-1];
            end
            pos_dly_reg[0] <= {in_reg.tz_in, in_reg.ty_in, in_reg.tx_in};
            for (int i = 1; i < DLY_POS; i++) begin
                pos_dly_reg[i] <= pos_dly_reg[i-1];
            end
            len_dly_reg[0] <= {len_e_reg[2], len_e_reg[1], len_e_reg[0]};
            for (int i = 1; i < DLY_LEN; i++) begin
                len_dly_reg[i] <= len_dly_reg[i-1];
            end
            vec_dly_reg[0] <= vec_q;
            for (int i = 1; i < DLY_SGN; i++) begin
                vec_dly_reg[i] <= vec_dly_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // rotation matrix: each component over its column length, Q2.30
    // ---------------------------------------------------------------
    logic [QUOT_W-1:0] quot1 [NCOMP];
    mat_t              mat_f_reg;

    genvar k;
    generate
        for (k = 0; k < NCOMP; k++) begin : g_unit
            tmd_div u_unit_div (
                .aclk (aclk),
                .en   (en),
                .num  (mag_dly_reg[DLY_MAG-1][k]),
                .den  (len_e_reg[k/3]),
                .quot (quot1[k])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NCOMP; i++) begin
                mat_f_reg[i] <= neg_dly_reg[DLY_NEG-1][i] ? -word_t'(quot1[i])
                                                           : word_t'(quot1[i]);
            end
        end
    end

    // ---------------------------------------------------------------
    // branch vector, block shift, then norm and per-component scaling
    // ---------------------------------------------------------------
    tmd_quat u_quat (
        .aclk (aclk),
        .en   (en),
        .m    (mat_f_reg),
        .vec  (vec_q)
    );

    logic [SQRT_IN_W-1:0] sq_g_reg [NQ];
    logic [SQRT_IN_W-1:0] sum_h_reg;
    logic [ROOT_W-1:0]    root2;
    uword_t               n_i_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NQ; i++) begin
                sq_g_reg[i] <= vec_q.mag[i] * vec_q.mag[i];
            end
            sum_h_reg <= sq_g_reg[0] + sq_g_reg[1] + sq_g_reg[2] + sq_g_reg[3];
            n_i_reg   <= (root2 == '0) ? uword_t'(1) : root2;
        end
    end

    tmd_isqrt u_norm_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (sum_h_reg),
        .root     (root2)
    );

    logic [QUOT_W-1:0] quot2 [NQ];

    generate
        for (k = 0; k < NQ; k++) begin : g_qdiv
            tmd_div u_quat_div (
                .aclk (aclk),
                .en   (en),
                .num  (uword_t'(vec_dly_reg[DLY_VEC-1].mag[k])),
                .den  (n_i_reg),
                .quot (quot2[k])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // output register: restore signs, join the side-band
    // ---------------------------------------------------------------
    word_t    qs [NQ];
    tmd_out_t out_reg;

    always_comb begin
        for (int i = 0; i < NQ; i++) begin
            qs[i] = vec_dly_reg[DLY_SGN-1].neg[i] ? -word_t'(quot2[i]) : word_t'(quot2[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.pos_x   <= pos_dly_reg[DLY_POS-1][0];
            out_reg.pos_y   <= pos_dly_reg[DLY_POS-1][1];
            out_reg.pos_z   <= pos_dly_reg[DLY_POS-1][2];
            out_reg.quat_w  <= qs[0];
            out_reg.quat_x  <= qs[1];
            out_reg.quat_y  <= qs[2];
            out_reg.quat_z  <= qs[3];
            out_reg.scale_x <= len_dly_reg[DLY_LEN-1][0];
            out_reg.scale_y <= len_dly_reg[DLY_LEN-1][1];
            out_reg.scale_z <= len_dly_reg[DLY_LEN-1][2];
        end
    end

    assign m_data = out_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !en) |-> !s_ready)
        else $error("input register would be overwritten during a stall");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_scale_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.scale_x != '0 && m_data.scale_y != '0 && m_data.scale_z != '0))
        else $error("zero scale delivered");

    a_quat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.quat_w <= 32'sh4000_0000 && m_data.quat_w >= -32'sh4000_0000 &&
                     m_data.quat_x <= 32'sh4000_0000 && m_data.quat_x >= -32'sh4000_0000 &&
                     m_data.quat_y <= 32'sh4000_0000 && m_data.quat_y >= -32'sh4000_0000 &&
                     m_data.quat_z <= 32'sh4000_0000 && m_data.quat_z >= -32'sh4000_0000))
        else $error("quaternion component above one");

endmodule

// File: hw/rtl/tmd_isqrt.sv
// Pipelined integer square root, floor(sqrt(radicand)), one root bit per stage.
// Depends on tmd_pkg.
module tmd_isqrt (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [tmd_pkg::SQRT_IN_W-1:0]  radicand,
    output logic [tmd_pkg::ROOT_W-1:0]     root
);
    import tmd_pkg::*;

    logic [SQRT_IN_W-1:0] x_reg    [SQRT_LAT-1];
    logic [REM_W-1:0]     rem_reg  [SQRT_LAT-1];
    logic [ROOT_W-1:0]    root_reg [SQRT_LAT];

    genvar k;
    generate
        for (k = 0; k < SQRT_LAT; k++) begin : g_stage
            localparam int BIT = 2 * (SQRT_LAT - 1 - k);
            logic [SQRT_IN_W-1:0] x_in;
            logic [REM_W-1:0]     rem_in;
            logic [ROOT_W-1:0]    root_in;
            logic [REM_W+1:0]     acc;
            logic [REM_W+1:0]     trial;
            logic                 ge;

            if (k == 0) begin : g_first
                assign x_in    = radicand;
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_next
                assign x_in    = x_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            // bring down the next radicand pair, try 4*root+1
            assign acc   = {rem_in, x_in[BIT+1:BIT]};
            assign trial = {2'b00, root_in, 2'b01};
            assign ge    = acc >= trial;

            always_ff @(posedge aclk) begin
                if (en) begin
                    root_reg[k] <= {root_in[ROOT_W-2:0], ge};
                end
            end

            if (k < SQRT_LAT - 1) begin : g_carry
                logic [REM_W-1:0] rem_next;
                assign rem_next = ge ? REM_W'(acc - trial) : acc[REM_W-1:0];
                always_ff @(posedge aclk) begin
                    if (en) begin
                        x_reg[k]   <= x_in;
                        rem_reg[k] <= rem_next;
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[SQRT_LAT-1];

endmodule

// File: hw/rtl/tmd_div.sv
// Pipelined restoring divider: floor(num * 2^30 / den) for num <= den.
// Depends on tmd_pkg.
module tmd_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [tmd_pkg::WORD_W-1:0]  num,
    input  logic [tmd_pkg::WORD_W-1:0]  den,
    output logic [tmd_pkg::QUOT_W-1:0]  quot
);
    import tmd_pkg::*;

    logic [WORD_W-1:0] r_reg   [DIV_LAT-1];
    logic [WORD_W-1:0] den_reg [DIV_LAT-1];
    logic [QUOT_W-1:0] q_reg   [DIV_LAT];

    genvar k;
    generate
        for (k = 0; k < DIV_LAT; k++) begin : g_stage
            logic [WORD_W:0]   r_in;
            logic [WORD_W-1:0] den_in;
            logic [QUOT_W-1:0] q_in;
            logic              ge;

            if (k == 0) begin : g_first
                // top quotient bit: num itself against den
                assign r_in   = {1'b0, num};
                assign den_in = den;
                assign q_in   = '0;
            end else begin : g_next
                assign r_in   = {r_reg[k-1], 1'b0};
                assign den_in = den_reg[k-1];
                assign q_in   = q_reg[k-1];
            end

            assign ge = r_in >= {1'b0, den_in};

            always_ff @(posedge aclk) begin
                if (en) begin
                    q_reg[k] <= {q_in[QUOT_W-2:0], ge};
                end
            end

            if (k < DIV_LAT - 1) begin : g_carry
                logic [WORD_W-1:0] r_next;
                assign r_next = ge ? WORD_W'(r_in - {1'b0, den_in}) : r_in[WORD_W-1:0];
                always_ff @(posedge aclk) begin
                    if (en) begin
                        r_reg[k]   <= r_next;
                        den_reg[k] <= den_in;
                    end
                end
            end
        end
    endgenerate

    assign quot = q_reg[DIV_LAT-1];

endmodule

// File: hw/rtl/tmd_quat.sv
// Quaternion branch selection and block normalization, six register stages.
// Depends on tmd_pkg.
module tmd_quat (
    input  logic               aclk,
    input  logic               en,
    input  tmd_pkg::mat_t      m,
    output tmd_pkg::tmd_qvec_t vec
);
    import tmd_pkg::*;

    localparam logic signed [VEC_W-1:0] ONE_Q30  = {{(VEC_W-31){1'b0}}, 1'b1, 30'b0};
    localparam logic        [MAG_W-1:0] MAG_TOP  = {{(MAG_W-31){1'b0}}, 1'b1, 30'b0};
    localparam logic        [MAG_W-1:0] MAG_HALF = {{(MAG_W-30){1'b0}}, 1'b1, 29'b0};

    // column-major: m00 m10 m20 m01 m11 m21 m02 m12 m22
    logic signed [VEC_W-1:0] e [NCOMP];
    logic signed [VEC_W-1:0] trace;

    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            e[i] = VEC_W'(m[i]);
        end
        trace = e[0] + e[4] + e[8];
    end

    // stage 1: trace, diagonal compares, all candidate terms
    logic                    tr_pos_reg;
    logic                    big00_reg;
    logic                    big11_reg;
    logic signed [VEC_W-1:0] rad_reg [NQ];
    logic signed [VEC_W-1:0] dif_reg [3];
    logic signed [VEC_W-1:0] sum_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            tr_pos_reg <= !trace[VEC_W-1] && (trace != '0);
            big00_reg  <= (e[0] > e[4]) && (e[0] > e[8]);
            big11_reg  <= e[4] > e[8];
            rad_reg[0] <= ONE_Q30 + trace;
            rad_reg[1] <= ONE_Q30 + e[0] - e[4] - e[8];
            rad_reg[2] <= ONE_Q30 + e[4] - e[0] - e[8];
            rad_reg[3] <= ONE_Q30 + e[8] - e[0] - e[4];
            dif_reg[0] <= e[5] - e[7];
            dif_reg[1] <= e[6] - e[2];
            dif_reg[2] <= e[1] - e[3];
            sum_reg[0] <= e[3] + e[1];
            sum_reg[1] <= e[6] + e[2];
            sum_reg[2] <= e[7] + e[5];
        end
    end

    // stage 2: pick the branch, clamp the radicand, split sign and magnitude
    logic signed [VEC_W-1:0] radc [NQ];
    logic signed [VEC_W-1:0] v    [NQ];
    logic [MAG_W-1:0]        mag2_reg [NQ];
    logic [NQ-1:0]           neg2_reg;

    always_comb begin
        for (int i = 0; i < NQ; i++) begin
            radc[i] = (rad_reg[i] > 0) ? rad_reg[i] : VEC_W'(1);
        end
        priority if (tr_pos_reg) begin
            v[0] = radc[0];    v[1] = dif_reg[0]; v[2] = dif_reg[1]; v[3] = dif_reg[2];
        end else if (big00_reg) begin
            v[0] = dif_reg[0]; v[1] = radc[1];    v[2] = sum_reg[0]; v[3] = sum_reg[1];
        end else if (big11_reg) begin
            v[0] = dif_reg[1]; v[1] = sum_reg[0]; v[2] = radc[2];    v[3] = sum_reg[2];
        end else begin
            v[0] = dif_reg[2]; v[1] = sum_reg[1]; v[2] = sum_reg[2]; v[3] = radc[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NQ; i++) begin
                neg2_reg[i] <= v[i][VEC_W-1];
                mag2_reg[i] <= v[i][VEC_W-1] ? MAG_W'(-v[i]) : MAG_W'(v[i]);
            end
        end
    end

    // stages 3 and 4: largest magnitude by a two-level tree
    logic [MAG_W-1:0] hi3_reg  [2];
    logic [MAG_W-1:0] mag3_reg [NQ];
    logic [NQ-1:0]    neg3_reg;
    logic [MAG_W-1:0] mx4_reg;
    logic [MAG_W-1:0] mag4_reg [NQ];
    logic [NQ-1:0]    neg4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            hi3_reg[0] <= (mag2_reg[0] > mag2_reg[1]) ? mag2_reg[0] : mag2_reg[1];
            hi3_reg[1] <= (mag2_reg[2] > mag2_reg[3]) ? mag2_reg[2] : mag2_reg[3];
            mag3_reg   <= mag2_reg;
            neg3_reg   <= neg2_reg;
            mx4_reg    <= (hi3_reg[0] > hi3_reg[1]) ? hi3_reg[0] : hi3_reg[1];
            mag4_reg   <= mag3_reg;
            neg4_reg   <= neg3_reg;
        end
    end

    // stage 5: shift amounts that bring the largest into [2^29, 2^30]
    logic [SHR_W-1:0] shr;
    logic [SHL_W-1:0] shl;
    logic [SHR_W-1:0] shr5_reg;
    logic [SHL_W-1:0] shl5_reg;
    logic [MAG_W-1:0] mag5_reg [NQ];
    logic [NQ-1:0]    neg5_reg;

    always_comb begin
        if (mx4_reg <= MAG_TOP) begin
            shr = SHR_W'(0);
        end else if ((mx4_reg >> 1) <= MAG_TOP) begin
            shr = SHR_W'(1);
        end else begin
            shr = SHR_W'(2);
        end
        shl = '0;
        if (mx4_reg < MAG_HALF) begin
            for (int b = 0; b < 29; b++) begin
                if (mx4_reg[b]) begin
                    shl = SHL_W'(29 - b);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            shr5_reg <= shr;
            shl5_reg <= shl;
            mag5_reg <= mag4_reg;
            neg5_reg <= neg4_reg;
        end
    end

    // stage 6: apply the common shift, drop bits shifted out
    tmd_qvec_t vec_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NQ; i++) begin
                vec_reg.mag[i] <= UNIT_W'((mag5_reg[i] >> shr5_reg) << shl5_reg);
            end
            vec_reg.neg <= neg5_reg;
        end
    end

    assign vec = vec_reg;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for trs_matrix_decompose: matrix transfers in, pose out.
// Depends on tmd_pkg and the block's RTL; predicts each pose in-line.
module tb_top;
    import tmd_pkg::*;

    localparam int PIPE_DEPTH  = 141;
    localparam int STALL_LIMIT = 20000;
    localparam int RAND_ITEMS  = 550;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    tmd_in_t   s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    tmd_out_t  m_data;

    tmd_in_t   pending_mats[$];
    tmd_out_t  expected_poses[$];
    int        err_count = 0;
    int        idle_cycles = 0;
    bit        quiet_phase = 0;   // no idling on either side
    bit        hold_sender = 0;   // pause the sender until the pipe drains
    bit        in_xfer_seen = 0;  // input transfer at the last rising edge

    trs_matrix_decompose dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // Exact integer square root, floor.
    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] magn(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] column_length(input word_t x, input word_t y,
                                                  input word_t z);
        logic [63:0] ax, ay, az, l;
        ax = magn(x); ay = magn(y); az = magn(z);
        l = isqrt(ax * ax + ay * ay + az * az);
        if (l > 64'hFFFF_FFFF) l = 64'hFFFF_FFFF;
        if (l == 0) l = 64'd1 << FRAC_BITS;
        return l;
    endfunction

    // Column entry divided by its length, Q2.30, toward zero.
    function automatic logic signed [63:0] unit_entry(input word_t c,
                                                       input logic [63:0] len);
        logic [63:0] q;
        q = (magn(c) << 30) / len;
        return c < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic tmd_out_t decompose(input tmd_in_t d);
        tmd_out_t o;
        logic [63:0] lx, ly, lz, mx, sum, n, q;
        logic signed [63:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, tr;
        logic signed [63:0] v [4];
        logic [63:0] a [4];
        logic signed [63:0] one;
        one = 64'sd1 << 30;
        lx = column_length(d.c0x, d.c0y, d.c0z);
        ly = column_length(d.c1x, d.c1y, d.c1z);
        lz = column_length(d.c2x, d.c2y, d.c2z);
        m00 = unit_entry(d.c0x, lx); m10 = unit_entry(d.c0y, lx); m20 = unit_entry(d.c0z, lx);
        m01 = unit_entry(d.c1x, ly); m11 = unit_entry(d.c1y, ly); m21 = unit_entry(d.c1z, ly);
        m02 = unit_entry(d.c2x, lz); m12 = unit_entry(d.c2y, lz); m22 = unit_entry(d.c2z, lz);
        tr = m00 + m11 + m22;
        if (tr > 0) begin
            v[0] = one + tr;
            v[1] = m21 - m12; v[2] = m02 - m20; v[3] = m10 - m01;
        end else if (m00 > m11 && m00 > m22) begin
            v[1] = one + m00 - m11 - m22;
            v[0] = m21 - m12; v[2] = m01 + m10; v[3] = m02 + m20;
        end else if (m11 > m22) begin
            v[2] = one + m11 - m00 - m22;
            v[0] = m02 - m20; v[1] = m01 + m10; v[3] = m12 + m21;
        end else begin
            v[3] = one + m22 - m00 - m11;
            v[0] = m10 - m01; v[1] = m02 + m20; v[2] = m12 + m21;
        end
        // clamp a non-positive radicand to one LSB
        for (int i = 0; i < 4; i++) begin
            if ((tr > 0 && i == 0) || (!(tr > 0) && m00 > m11 && m00 > m22 && i == 1)
                || (!(tr > 0) && !(m00 > m11 && m00 > m22) && m11 > m22 && i == 2)
                || (!(tr > 0) && !(m00 > m11 && m00 > m22) && !(m11 > m22) && i == 3))
                if (v[i] <= 0) v[i] = 1;
        end
        mx = 0;
        for (int i = 0; i < 4; i++) begin
            a[i] = magn(v[i]);
            if (a[i] > mx) mx = a[i];
        end
        while (mx > (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 4; i++) a[i] = a[i] >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 4; i++) a[i] = a[i] << 1;
        end
        sum = 0;
        for (int i = 0; i < 4; i++) sum = sum + a[i] * a[i];
        n = isqrt(sum);
        if (n == 0) n = 1;
        o.pos_x = d.tx_in; o.pos_y = d.ty_in; o.pos_z = d.tz_in;
        q = (a[0] << 30) / n; o.quat_w = v[0] < 0 ? -q[31:0] : q[31:0];
        q = (a[1] << 30) / n; o.quat_x = v[1] < 0 ? -q[31:0] : q[31:0];
        q = (a[2] << 30) / n; o.quat_y = v[2] < 0 ? -q[31:0] : q[31:0];
        q = (a[3] << 30) / n; o.quat_z = v[3] < 0 ? -q[31:0] : q[31:0];
        o.scale_x = lx[31:0]; o.scale_y = ly[31:0]; o.scale_z = lz[31:0];
        return o;
    endfunction

    function automatic word_t rand_word(input int spread);
        case (spread)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
            default: return $signed($urandom_range(0, 32'h0000_0200)) - 32'sh100;
        endcase
    endfunction

    function automatic tmd_in_t rand_matrix();
        tmd_in_t d;
        int sp;
        sp = $urandom_range(0, 2);
        d.c0x = rand_word(sp); d.c0y = rand_word(sp); d.c0z = rand_word(sp);
        d.c1x = rand_word(sp); d.c1y = rand_word(sp); d.c1z = rand_word(sp);
        d.c2x = rand_word(sp); d.c2y = rand_word(sp); d.c2z = rand_word(sp);
        d.tx_in = $urandom; d.ty_in = $urandom; d.tz_in = $urandom;
        // occasionally zero a column to hit the unit-scale substitute
        if ($urandom_range(0, 15) == 0) begin
            d.c1x = 0; d.c1y = 0; d.c1z = 0;
        end
        return d;
    endfunction

    // Build a signed-permutation basis scaled by k: hits every branch.
    function automatic tmd_in_t axis_matrix(input int perm, input int sgn,
                                            input word_t k);
        tmd_in_t d;
        word_t c [9];
        int p [3];
        for (int i = 0; i < 9; i++) c[i] = 0;
        case (perm)
            0: p = '{0, 1, 2};
            1: p = '{1, 0, 2};
            2: p = '{0, 2, 1};
            3: p = '{2, 1, 0};
            4: p = '{1, 2, 0};
            default: p = '{2, 0, 1};
        endcase
        for (int j = 0; j < 3; j++)
            c[3 * j + p[j]] = sgn[j] ? -k : k;
        d = '0;
        d.c0x = c[0]; d.c0y = c[1]; d.c0z = c[2];
        d.c1x = c[3]; d.c1y = c[4]; d.c1z = c[5];
        d.c2x = c[6]; d.c2y = c[7]; d.c2z = c[8];
        d.tx_in = $urandom; d.ty_in = $urandom; d.tz_in = $urandom;
        return d;
    endfunction

    // Driver: present pending matrices, idle at random.
    always @(negedge aclk) begin
        bit idle;
        idle = !quiet_phase && ($urandom_range(0, 99) < 35);
        if (aresetn) begin
            if (s_valid && !in_xfer_seen) begin
                // hold until transferred
            end else if (pending_mats.size() > 0 && !idle && !hold_sender) begin
                s_data  <= pending_mats.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
            m_ready <= quiet_phase || ($urandom_range(0, 99) >= 35);
        end
    end

    // Monitor: predict on input transfer, check on output transfer.
    always @(posedge aclk) begin
        tmd_out_t exp_pose;
        in_xfer_seen <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) expected_poses = {expected_poses, decompose(s_data)};
            if (m_valid && m_ready) begin
                if (expected_poses.size() == 0) begin
                    $error("pose with no matrix outstanding");
                    err_count++;
                end else begin
                    exp_pose = expected_poses.pop_front();
                    if (m_data.pos_x !== exp_pose.pos_x) begin
                        $error("pos_x exp %h got %h", exp_pose.pos_x, m_data.pos_x); err_count++;
                    end
                    if (m_data.pos_y !== exp_pose.pos_y) begin
                        $error("pos_y exp %h got %h", exp_pose.pos_y, m_data.pos_y); err_count++;
                    end
                    if (m_data.pos_z !== exp_pose.pos_z) begin
                        $error("pos_z exp %h got %h", exp_pose.pos_z, m_data.pos_z); err_count++;
                    end
                    if (m_data.quat_w !== exp_pose.quat_w) begin
                        $error("quat_w exp %h got %h", exp_pose.quat_w, m_data.quat_w); err_count++;
                    end
                    if (m_data.quat_x !== exp_pose.quat_x) begin
                        $error("quat_x exp %h got %h", exp_pose.quat_x, m_data.quat_x); err_count++;
                    end
                    if (m_data.quat_y !== exp_pose.quat_y) begin
                        $error("quat_y exp %h got %h", exp_pose.quat_y, m_data.quat_y); err_count++;
                    end
                    if (m_data.quat_z !== exp_pose.quat_z) begin
                        $error("quat_z exp %h got %h", exp_pose.quat_z, m_data.quat_z); err_count++;
                    end
                    if (m_data.scale_x !== exp_pose.scale_x) begin
                        $error("scale_x exp %h got %h", exp_pose.scale_x, m_data.scale_x);
                        err_count++;
                    end
                    if (m_data.scale_y !== exp_pose.scale_y) begin
                        $error("scale_y exp %h got %h", exp_pose.scale_y, m_data.scale_y);
                        err_count++;
                    end
                    if (m_data.scale_z !== exp_pose.scale_z) begin
                        $error("scale_z exp %h got %h", exp_pose.scale_z, m_data.scale_z);
                        err_count++;
                    end
                end
            end
            // Watchdog: count cycles without any transfer.
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("trs_matrix_decompose verification failed");
            $finish;
        end
    end

    initial begin
        tmd_in_t d;
        // Directed: extremes, zero matrix, every branch via signed permutations.
        d = '0;
        pending_mats = {pending_mats, d};
        d = '1;
        pending_mats = {pending_mats, d};
        d.c0x = 32'sh7FFF_FFFF; d.c0y = 32'sh7FFF_FFFF; d.c0z = 32'sh7FFF_FFFF;
        d.c1x = 32'sh8000_0000; d.c1y = 32'sh8000_0000; d.c1z = 32'sh8000_0000;
        d.c2x = 32'sh8000_0000; d.c2y = 32'sh7FFF_FFFF; d.c2z = 0;
        d.tx_in = 32'sh7FFF_FFFF; d.ty_in = 32'sh8000_0000; d.tz_in = 0;
        pending_mats = {pending_mats, d};
        for (int perm = 0; perm < 6; perm++)
            for (int sgn = 0; sgn < 8; sgn += 3)
                pending_mats = {pending_mats, axis_matrix(perm, sgn, 32'sh0001_0000)};
        pending_mats = {pending_mats, axis_matrix(0, 7, 32'sh8000_0000)};
        pending_mats = {pending_mats, axis_matrix(3, 5, 32'sh7FFF_FFFF)};
        pending_mats = {pending_mats, axis_matrix(0, 0, 32'sd1)};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain the directed set with the sender held back.
        wait (pending_mats.size() == 0 && !s_valid);
        hold_sender = 1;
        wait (expected_poses.size() == 0);
        hold_sender = 0;

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if ($urandom_range(0, 1)) d = rand_matrix();
            else d = axis_matrix($urandom_range(0, 5), $urandom_range(0, 7), rand_word(0));
            pending_mats = {pending_mats, d};
            if (i == 200) begin
                quiet_phase = 1;
                wait (pending_mats.size() == 0);
            end
            if (i == 350) quiet_phase = 0;
        end
        // every matrix has left the driver once valid drops with nothing pending
        wait (pending_mats.size() == 0 && !s_valid);
        wait (expected_poses.size() == 0);
        repeat (PIPE_DEPTH + 20) @(posedge aclk);
        if (err_count == 0) $display("trs_matrix_decompose verification clean");
        else $display("trs_matrix_decompose verification failed");
        $finish;
    end
endmodule
